[hw/rtl/chm_pkg.sv]
// Package for the chained hash map: field widths, operation and status codes,
// default sizes. No dependencies.
`timescale 1ns / 1ps

package chm_pkg;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;

  localparam int DEF_BUCKETS = 1024;
  localparam int DEF_NODES = 1024;

  localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] OP_FIND   = 2'd1;
  localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [FUNC_W-1:0] OP_SPARE  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
endpackage

[hw/rtl/chm_if.sv]
// Request and response channel interfaces of the chained hash map.
// Depends on chm_pkg.
`timescale 1ns / 1ps

interface chm_req_if
  import chm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  key_in;
  logic [VAL_W-1:0]  value_in;

  modport source (output valid, output func, output key_in, output value_in, input ready);
  modport sink (input valid, input func, input key_in, input value_in, output ready);
endinterface

interface chm_rsp_if
  import chm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  value_out;

  modport source (output valid, output status, output value_out, input ready);
  modport sink (input valid, input status, input value_out, output ready);
endinterface

[hw/rtl/chm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module chm_ram #(
  parameter int W = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/chm_mod.sv]
// Bucket index unit: key modulo BUCKETS. A mask for a power of two, else a
// reciprocal multiply, a back-multiply and one correcting subtract, each
// registered. Depends on chm_pkg.
`timescale 1ns / 1ps

module chm_mod
  import chm_pkg::*;
#(
  parameter int BUCKETS = DEF_BUCKETS,
  localparam int BW = $clog2(BUCKETS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  output logic             done,
  output logic [BW-1:0]    rem
);
  if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_mask
    always_ff @(posedge clk) begin
      if (rst) begin
        done <= 1'b0;
      end else begin
        done <= start;
      end
      if (start) begin
        rem <= key[BW-1:0];
      end
    end
  end else begin : g_recip
    // quotient estimate is exact or one low, so one subtract corrects it
    localparam int SH = KEY_W - 1 + BW;
    localparam longint unsigned MQ = (64'd1 << SH) / BUCKETS;
    localparam logic [KEY_W-1:0] MUL = KEY_W'(MQ);
    localparam logic [KEY_W:0] BVAL = (KEY_W + 1)'(BUCKETS);
    logic [2*KEY_W-1:0] prod;
    logic [KEY_W-1:0]   k;
    logic [KEY_W:0]     qb;
    logic [KEY_W:0]     diff;
    logic               s1, s2;

    assign diff = {1'b0, k} - qb;

    always_ff @(posedge clk) begin
      if (rst) begin
        s1 <= 1'b0;
        s2 <= 1'b0;
        done <= 1'b0;
      end else begin
        s1 <= start;
        s2 <= s1;
        done <= s2;
      end
      if (start) begin
        prod <= {{KEY_W{1'b0}}, key} * {{KEY_W{1'b0}}, MUL};
        k <= key;
      end
      if (s1) begin
        qb <= {{BW{1'b0}}, prod[2*KEY_W-1:SH]} * BVAL;
      end
      if (s2) begin
        rem <= (diff >= BVAL) ? BW'(diff - BVAL) : diff[BW-1:0];
      end
    end
  end
endmodule

[hw/rtl/chained_hash_map.sv]
// Chained hash map: one request word in, one response word out per request.
// A request is taken in the idle state, then passes the bucket index (by the
// reciprocal remainder unit when BUCKETS is not a power of two), the bucket
// head read, a walk that reads each chain node visited on the node memory
// read port, the update and the result. The next request is taken while a
// response word waits. After reset a clearing pass writes NIL to every bucket
// head entry; no request is taken during it.
// Depends on chm_pkg, chm_if, chm_ram, chm_mod.
`timescale 1ns / 1ps

module chained_hash_map
  import chm_pkg::*;
#(
  parameter int BUCKETS = DEF_BUCKETS,
  parameter int NODES = DEF_NODES
) (
  input logic       clk,
  input logic       rst,
  chm_req_if.sink   req,
  chm_rsp_if.source rsp
);
  localparam int BW = $clog2(BUCKETS);
  localparam int NAW = $clog2(NODES);
  localparam int NW = $clog2(NODES + 1);
  localparam int EW = KEY_W + VAL_W + NW;
  localparam logic [NW-1:0] NIL = NW'(NODES);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_MOD    = 4'd2;
  localparam logic [3:0] S_HEAD   = 4'd3;
  localparam logic [3:0] S_WALK   = 4'd4;
  localparam logic [3:0] S_DECIDE = 4'd5;
  localparam logic [3:0] S_ALLOC  = 4'd6;
  localparam logic [3:0] S_WNODE  = 4'd7;
  localparam logic [3:0] S_WLINK  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]        state;
  logic [BW-1:0]     clr;
  logic [FUNC_W-1:0] op_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  logic [BW-1:0]     b_q;
  logic [NW-1:0]     cur, prev, cur_link, newn, link_val, free_head, fresh;
  logic [VAL_W-1:0]  cur_val, prev_val;
  logic [KEY_W-1:0]  prev_key;
  logic              found;
  logic [STAT_W-1:0] st_q, out_status;
  logic [VAL_W-1:0]  vo_q, out_value;
  logic              out_valid;

  logic              mod_start, mod_done;
  logic [BW-1:0]     mod_rem;

  logic              h_we;
  logic [BW-1:0]     h_waddr;
  logic [NW-1:0]     h_wdata, h_rd;
  logic              n_we;
  logic [NAW-1:0]    n_waddr, n_raddr;
  logic [EW-1:0]     n_wdata, n_rd;
  logic [KEY_W-1:0]  n_key;
  logic [VAL_W-1:0]  n_val;
  logic [NW-1:0]     n_link;
  logic              accept;

  assign n_key = n_rd[EW-1 -: KEY_W];
  assign n_val = n_rd[NW +: VAL_W];
  assign n_link = n_rd[NW-1:0];

  assign req.ready = (state == S_IDLE);
  assign accept = req.valid && req.ready;
  assign mod_start = accept;
  assign rsp.valid = out_valid;
  assign rsp.status = out_status;
  assign rsp.value_out = out_value;

  chm_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .key(req.key_in),
    .done(mod_done), .rem(mod_rem)
  );

  chm_ram #(.W(NW), .DEPTH(BUCKETS)) u_head (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(mod_rem), .rdata(h_rd)
  );

  chm_ram #(.W(EW), .DEPTH(NODES)) u_node (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rd)
  );

  // memory port control
  always_comb begin
    h_we = 1'b0;
    h_waddr = b_q;
    h_wdata = link_val;
    n_we = 1'b0;
    n_waddr = cur[NAW-1:0];
    n_wdata = {key_q, val_q, cur_link};
    case (state)
      S_HEAD: n_raddr = h_rd[NAW-1:0];
      S_WALK: n_raddr = n_link[NAW-1:0];
      default: n_raddr = free_head[NAW-1:0];
    endcase
    case (state)
      S_CLR: begin
        h_we = 1'b1;
        h_waddr = clr;
        h_wdata = NIL;
      end
      S_DECIDE: begin
        if (found && op_q == OP_INSERT) begin
          n_we = 1'b1;
          n_wdata = {key_q, val_q, cur_link};
        end else if (found && op_q == OP_REMOVE) begin
          n_we = 1'b1;
          n_wdata = {key_q, cur_val, free_head};
        end
      end
      S_WNODE: begin
        n_we = 1'b1;
        n_waddr = newn[NAW-1:0];
        n_wdata = {key_q, val_q, NIL};
      end
      S_WLINK: begin
        if (prev != NIL) begin
          n_we = 1'b1;
          n_waddr = prev[NAW-1:0];
          n_wdata = {prev_key, prev_val, link_val};
        end else begin
          h_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr <= '0;
      fresh <= '0;
      free_head <= NIL;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr <= clr + 1'b1;
          if (clr == BW'(BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          state <= (h_rd != NIL) ? S_WALK : S_DECIDE;
        end
        S_WALK: begin
          if (n_key == key_q || n_link == NIL) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= S_DONE;
          if (op_q == OP_INSERT && !found) begin
            if (free_head != NIL) begin
              state <= S_ALLOC;
            end else if (fresh != NIL) begin
              fresh <= fresh + 1'b1;
              state <= S_WNODE;
            end
          end else if (op_q == OP_REMOVE && found) begin
            free_head <= cur;
            state <= S_WLINK;
          end
        end
        S_ALLOC: begin
          free_head <= n_link;
          state <= S_WNODE;
        end
        S_WNODE: state <= S_WLINK;
        S_WLINK: state <= S_DONE;
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op_q <= req.func;
        key_q <= req.key_in;
        val_q <= req.value_in;
      end
      S_MOD: b_q <= mod_rem;
      S_HEAD: begin
        cur <= h_rd;
        prev <= NIL;
        found <= 1'b0;
      end
      S_WALK: begin
        if (n_key == key_q) begin
          found <= 1'b1;
          cur_val <= n_val;
          cur_link <= n_link;
        end else begin
          prev <= cur;
          prev_key <= n_key;
          prev_val <= n_val;
          cur <= n_link;
        end
      end
      S_DECIDE: begin
        st_q <= ST_OK;
        vo_q <= '0;
        newn <= fresh;
        link_val <= cur_link;
        case (op_q)
          OP_INSERT: begin
            if (!found && free_head == NIL && fresh == NIL) begin
              st_q <= ST_FULL;
            end
          end
          OP_FIND: begin
            if (found) begin
              vo_q <= cur_val;
            end else begin
              st_q <= ST_ABSENT;
            end
          end
          OP_REMOVE: begin
            if (!found) begin
              st_q <= ST_ABSENT;
            end
          end
          default: ;
        endcase
      end
      S_ALLOC: newn <= free_head;
      S_WNODE: link_val <= newn;
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_status <= st_q;
          out_value <= vo_q;
        end
      end
      default: ;
    endcase
  end
endmodule

[hw/rtl/chm_checker.sv]
// Port-level checks for chained_hash_map, attached by bind.
// Depends on chm_pkg.
`timescale 1ns / 1ps

module chm_checker
  import chm_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [STAT_W-1:0] rsp_status,
  input logic [VAL_W-1:0]  rsp_value_out
);
  // hold a stalled response word
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response word dropped while stalled");

  // one request in flight at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_ABSENT || rsp_status == ST_FULL)
    else $error("bad status code");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_value_out == '0)
    else $error("value on failed request");
endmodule

bind chained_hash_map chm_checker u_chk (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_status(rsp.status), .rsp_value_out(rsp.value_out)
);
